// File: sv/htsamp_pkg.sv
// ----------------------------------------------------------------------------
// htsamp_pkg
// Shared types and constants for the heightmap triangle height sampler:
// controller states, command/status structs, fixed field widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package htsamp_pkg;

  localparam int GRID_SIDE_DEF = 256;

  localparam int FIELD_W = 16;
  localparam int GRID_CFG_W = 9;
  localparam int FRAC_BITS = 8;
  localparam int SCALED_W = 2 * FIELD_W;
  localparam int FRAC_W = SCALED_W - FRAC_BITS;
  localparam int WGT_W = FRAC_W + 1;
  localparam int DIFF_W = FIELD_W + 1;
  localparam int MULT_W = WGT_W + DIFF_W;
  localparam int ACC_W = MULT_W + 3;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OFFSET = 2'd3;

  localparam logic [GRID_CFG_W-1:0] GRID_COLUMNS_RST = 9'd256;
  localparam logic [GRID_CFG_W-1:0] GRID_ROWS_RST = 9'd256;
  localparam logic [FIELD_W-1:0] INV_CELL_SIZE_RST = 16'd1306;
  localparam logic [FIELD_W-1:0] HEIGHT_OFFSET_RST = 16'd51;

  // neighbor selects for the four corner reads
  localparam logic [1:0] NB_00 = 2'd0;
  localparam logic [1:0] NB_01 = 2'd1;
  localparam logic [1:0] NB_10 = 2'd2;
  localparam logic [1:0] NB_11 = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOC,
    S_BASE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RDW,
    S_MUL,
    S_SUM
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       mem_wr;
    logic       loc_en;
    logic       base_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       mul_en;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: sv/htsamp_ctrl.sv
// ----------------------------------------------------------------------------
// htsamp_ctrl
// Sequencer for the sampler: takes one transaction at a time, steps a query
// through locate, address, four corner reads, multiply and sum.
// ----------------------------------------------------------------------------
module htsamp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  htsamp_pkg::ctrl_sts_t  sts,
  output htsamp_pkg::ctrl_cmd_t  cmd
);
  import htsamp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.is_query) begin
            cmd.capture = 1'b1;
            state_next = S_LOC;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      S_LOC: begin
        cmd.loc_en = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.base_en = 1'b1;
        state_next = S_RD0;
      end
      S_RD0: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = NB_00;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = NB_01;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = NB_00;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = NB_10;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = NB_01;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = NB_11;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = NB_10;
        state_next = S_RDW;
      end
      S_RDW: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = NB_11;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/htsamp_dp.sv
// ----------------------------------------------------------------------------
// htsamp_dp
// Datapath: configuration registers, height store, cell locate, corner
// address generation, triangle plane interpolation and output register.
// ----------------------------------------------------------------------------
module htsamp_dp #(
  parameter int GRID_SIDE = htsamp_pkg::GRID_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [htsamp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htsamp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                   req_type,
  input  logic [htsamp_pkg::FIELD_W-1:0]         cell_index,
  input  logic [htsamp_pkg::FIELD_W-1:0]         sample_height,
  input  logic [htsamp_pkg::FIELD_W-1:0]         pos_x,
  input  logic [htsamp_pkg::FIELD_W-1:0]         pos_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [htsamp_pkg::FIELD_W-1:0]         height_out,
  output logic                                   saturated,
  input  htsamp_pkg::ctrl_cmd_t                  cmd,
  output htsamp_pkg::ctrl_sts_t                  sts
);
  import htsamp_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(GRID_SIDE + 1);
  localparam int CW = $clog2(GRID_SIDE);

  function automatic logic [DW-1:0] clamp_dim(input logic [GRID_CFG_W-1:0] v);
    if (32'(v) < 32'd2) begin
      return DW'(2);
    end else if (32'(v) > 32'(GRID_SIDE)) begin
      return DW'(GRID_SIDE);
    end else begin
      return DW'(v);
    end
  endfunction

  logic [GRID_CFG_W-1:0] grid_columns;
  logic [GRID_CFG_W-1:0] grid_rows;
  logic [FIELD_W-1:0]    inverse_cell_size;
  logic [FIELD_W-1:0]    height_offset;

  logic [FIELD_W-1:0]    mem [DEPTH];
  logic [FIELD_W-1:0]    rdata;
  logic [SCALED_W-1:0]   sx;
  logic [SCALED_W-1:0]   sz;
  logic [CW-1:0]         col;
  logic [CW-1:0]         row;
  logic [FRAC_W-1:0]     fx;
  logic [FRAC_W-1:0]     fz;
  logic [AW-1:0]         base;
  logic [FIELD_W-1:0]    h [4];
  logic signed [MULT_W-1:0] p1;
  logic signed [MULT_W-1:0] p2;
  logic [FIELD_W-1:0]    hb;

  logic [DW-1:0]         cols;
  logic [DW-1:0]         rows;
  logic [FIELD_W-1:0]    cx;
  logic [FIELD_W-1:0]    cz;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         rd_off;
  logic                  wr_ok;
  logic                  lower;
  logic signed [WGT_W-1:0]  w1;
  logic signed [WGT_W-1:0]  w2;
  logic signed [DIFF_W-1:0] d1;
  logic signed [DIFF_W-1:0] d2;
  logic [ACC_W-1:0]      acc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= GRID_COLUMNS_RST;
      grid_rows <= GRID_ROWS_RST;
      inverse_cell_size <= INV_CELL_SIZE_RST;
      height_offset <= HEIGHT_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLUMNS:  grid_columns <= cfg_data[GRID_CFG_W-1:0];
        REG_GRID_ROWS:     grid_rows <= cfg_data[GRID_CFG_W-1:0];
        REG_INV_CELL_SIZE: inverse_cell_size <= cfg_data[FIELD_W-1:0];
        REG_HEIGHT_OFFSET: height_offset <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cols = clamp_dim(grid_columns);
  assign rows = clamp_dim(grid_rows);

  assign sts.is_query = req_type;
  assign sts.out_free = !out_valid || out_ready;

  // height store, single port
  assign wr_ok = 32'(cell_index) < 32'(DEPTH);

  always_comb begin
    case (cmd.rd_sel)
      NB_00:   rd_off = '0;
      NB_01:   rd_off = AW'(1);
      NB_10:   rd_off = AW'(cols);
      NB_11:   rd_off = AW'(cols) + AW'(1);
      default: rd_off = '0;
    endcase
  end

  assign rd_addr = base + rd_off;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      mem[AW'(cell_index)] <= sample_height;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // scale, locate and address
  always_comb begin
    cx = (sx[SCALED_W-1:FIELD_W] > FIELD_W'(cols - DW'(2))) ?
         FIELD_W'(cols - DW'(2)) : sx[SCALED_W-1:FIELD_W];
    cz = (sz[SCALED_W-1:FIELD_W] > FIELD_W'(rows - DW'(2))) ?
         FIELD_W'(rows - DW'(2)) : sz[SCALED_W-1:FIELD_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx <= SCALED_W'(pos_x) * SCALED_W'(inverse_cell_size);
      sz <= SCALED_W'(pos_z) * SCALED_W'(inverse_cell_size);
    end
    if (cmd.loc_en) begin
      col <= CW'(cx);
      row <= CW'(cz);
      fx <= sx[SCALED_W-1:FRAC_BITS] - {cx, {FRAC_BITS{1'b0}}};
      fz <= sz[SCALED_W-1:FRAC_BITS] - {cz, {FRAC_BITS{1'b0}}};
    end
    if (cmd.base_en) begin
      base <= AW'(row) * AW'(cols) + AW'(col);
    end
    if (cmd.cap_en) begin
      h[cmd.cap_sel] <= rdata;
    end
  end

  // triangle select and plane weights
  assign lower = ({1'b0, fx} + {1'b0, fz}) < WGT_W'(ONE);

  always_comb begin
    if (lower) begin
      w1 = $signed({1'b0, fx});
      w2 = $signed({1'b0, fz});
      d1 = $signed({1'b0, h[NB_01]}) - $signed({1'b0, h[NB_00]});
      d2 = $signed({1'b0, h[NB_10]}) - $signed({1'b0, h[NB_00]});
    end else begin
      w1 = $signed(WGT_W'(ONE)) - $signed({1'b0, fx});
      w2 = $signed(WGT_W'(ONE)) - $signed({1'b0, fz});
      d1 = $signed({1'b0, h[NB_10]}) - $signed({1'b0, h[NB_11]});
      d2 = $signed({1'b0, h[NB_01]}) - $signed({1'b0, h[NB_11]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p1 <= w1 * d1;
      p2 <= w2 * d2;
      hb <= lower ? h[NB_00] : h[NB_11];
    end
  end

  // offset, round half up, saturate
  assign acc = ACC_W'(p1) + ACC_W'(p2) + ACC_W'({hb, {FRAC_BITS{1'b0}}})
             + ACC_W'({height_offset, {FRAC_BITS{1'b0}}}) + ACC_W'(HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (acc[ACC_W-1]) begin
        height_out <= '0;
        saturated <= 1'b1;
      end else if (|acc[ACC_W-2:FRAC_BITS+FIELD_W]) begin
        height_out <= '1;
        saturated <= 1'b1;
      end else begin
        height_out <= acc[FRAC_BITS+FIELD_W-1:FRAC_BITS];
        saturated <= 1'b0;
      end
    end
  end

endmodule

// File: sv/heightmap_triangle_height_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_triangle_height_sampler
// Terrain height sampler: write transactions fill a grid of Q8.8 heights,
// query transactions return the triangle-plane height at a world point.
//
//   channel  signals                                        direction
//   in       in_valid/in_ready, req_type, cell_index,       input
//            sample_height, pos_x, pos_z
//   out      out_valid/out_ready, height_out, saturated     output
//   cfg      cfg_we, cfg_index, cfg_data                    input
//
// A write completes on acceptance and leaves the sampler ready; a query
// holds off the next accept while it steps through locate, address, four
// corner reads through the single-port height store, multiply and sum.
// A result waits in the output register; a query that finishes while it is
// still full holds in its last step until out_ready frees it.
// Reset clears the sequencer and output valid; the store is not cleared.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_sampler #(
  parameter int GRID_SIDE = htsamp_pkg::GRID_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [htsamp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htsamp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [htsamp_pkg::FIELD_W-1:0]    cell_index,
  input  logic [htsamp_pkg::FIELD_W-1:0]    sample_height,
  input  logic [htsamp_pkg::FIELD_W-1:0]    pos_x,
  input  logic [htsamp_pkg::FIELD_W-1:0]    pos_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [htsamp_pkg::FIELD_W-1:0]    height_out,
  output logic                              saturated
);
  import htsamp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  htsamp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  htsamp_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .cell_index    (cell_index),
    .sample_height (sample_height),
    .pos_x         (pos_x),
    .pos_z         (pos_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .height_out    (height_out),
    .saturated     (saturated),
    .cmd           (cmd),
    .sts           (sts)
  );

  // single-port store: never a read and a write together
  assert property (@(posedge clk) disable iff (rst) !(cmd.mem_wr && cmd.rd_en))
    else $error("store read and write in the same cycle");

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (rst) cmd.load_out |-> sts.out_free)
    else $error("result loaded while output register busy");

  // queries start only on an accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (in_valid && in_ready && req_type))
    else $error("query captured without a transaction");

  // a write transaction yields no result
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !req_type) |=> !cmd.load_out)
    else $error("write transaction produced a result");

endmodule
